// File: hw/rtl/s20_pkg.sv
// Shared types and constants of the Salsa20 stream cipher.
// No dependencies; imported by the core, the ARX lane, the top level and the testbench.
`default_nettype none

package s20_pkg;

    // Sixteen 32-bit state words, word 0 in the lowest bits
    typedef logic [15:0][31:0] t_words;

    // "expand 32-byte k" constant words
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY_LOW    = 3'd0;
    localparam logic [2:0] REG_KEY_SECOND = 3'd1;
    localparam logic [2:0] REG_KEY_THIRD  = 3'd2;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd3;
    localparam logic [2:0] REG_NONCE      = 3'd4;
    localparam logic [2:0] REG_COUNTER    = 3'd5;

    // Quarter-round steps
    localparam logic [1:0] STEP_B = 2'd0;
    localparam logic [1:0] STEP_C = 2'd1;
    localparam logic [1:0] STEP_D = 2'd2;
    localparam logic [1:0] STEP_A = 2'd3;

    // Word index of position pos of quarter-round lane, column or row round
    function automatic logic [3:0] quarter_word(input logic row, input logic [1:0] lane,
                                                input logic [1:0] pos);
        logic [3:0] idx;
        idx = 4'd0;
        if (!row) begin
            unique case (lane)
                2'd0: idx = (pos == 2'd0) ? 4'd0  : (pos == 2'd1) ? 4'd4  :
                            (pos == 2'd2) ? 4'd8  : 4'd12;
                2'd1: idx = (pos == 2'd0) ? 4'd5  : (pos == 2'd1) ? 4'd9  :
                            (pos == 2'd2) ? 4'd13 : 4'd1;
                2'd2: idx = (pos == 2'd0) ? 4'd10 : (pos == 2'd1) ? 4'd14 :
                            (pos == 2'd2) ? 4'd2  : 4'd6;
                2'd3: idx = (pos == 2'd0) ? 4'd15 : (pos == 2'd1) ? 4'd3  :
                            (pos == 2'd2) ? 4'd7  : 4'd11;
                default: idx = 4'd0;
            endcase
        end else begin
            unique case (lane)
                2'd0: idx = (pos == 2'd0) ? 4'd0  : (pos == 2'd1) ? 4'd1  :
                            (pos == 2'd2) ? 4'd2  : 4'd3;
                2'd1: idx = (pos == 2'd0) ? 4'd5  : (pos == 2'd1) ? 4'd6  :
                            (pos == 2'd2) ? 4'd7  : 4'd4;
                2'd2: idx = (pos == 2'd0) ? 4'd10 : (pos == 2'd1) ? 4'd11 :
                            (pos == 2'd2) ? 4'd8  : 4'd9;
                2'd3: idx = (pos == 2'd0) ? 4'd15 : (pos == 2'd1) ? 4'd12 :
                            (pos == 2'd2) ? 4'd13 : 4'd14;
                default: idx = 4'd0;
            endcase
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/s20_arx.sv
// One add-rotate-xor lane of the shared round unit.
// Depends on s20_pkg for the step codes.
`default_nettype none

module s20_arx import s20_pkg::*; (
    input  wire logic [1:0]  i_step,
    input  wire logic [31:0] i_src_a,
    input  wire logic [31:0] i_src_b,
    input  wire logic [31:0] i_tgt,
    output logic      [31:0] o_tgt
);

    logic [31:0] w_sum;
    logic [31:0] w_rot;

    // Add the two sources, rotate by the step's amount, fold into the target
    always_comb begin
        w_sum = i_src_a + i_src_b;
        unique case (i_step)
            STEP_B:  w_rot = {w_sum[24:0], w_sum[31:25]};
            STEP_C:  w_rot = {w_sum[22:0], w_sum[31:23]};
            STEP_D:  w_rot = {w_sum[18:0], w_sum[31:19]};
            STEP_A:  w_rot = {w_sum[13:0], w_sum[31:14]};
            default: w_rot = w_sum;
        endcase
        o_tgt = i_tgt ^ w_rot;
    end

endmodule

`default_nettype wire

// File: hw/rtl/s20_core.sv
// Block generator: round state, round sequencer and four shared ARX lanes.
// Depends on s20_pkg and s20_arx. One quarter-round step per cycle on all lanes.
`default_nettype none

module s20_core import s20_pkg::*; #(
    parameter int ROUND_COUNT = 20
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_words i_init,
    output logic        o_done,
    output t_words      o_block
);

    localparam int RW = $clog2(ROUND_COUNT);
    localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_RUN  = 3'b010,
        CS_DONE = 3'b100
    } t_core_state;

    t_core_state   r_state;
    logic [RW-1:0] r_round;
    logic [1:0]    r_step;
    t_words        r_st;
    t_words        n_st;

    logic [3:0]  w_tgt_idx [4];
    logic [31:0] w_res     [4];

    // Route state words to the four lanes for the current step
    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [3:0] w_a_idx;
        logic [3:0] w_b_idx;
        always_comb begin
            w_a_idx      = quarter_word(r_round[0], 2'(g), r_step);
            w_b_idx      = quarter_word(r_round[0], 2'(g), r_step + 2'd3);
            w_tgt_idx[g] = quarter_word(r_round[0], 2'(g), r_step + 2'd1);
        end
        s20_arx u_arx (
            .i_step  (r_step),
            .i_src_a (r_st[w_a_idx]),
            .i_src_b (r_st[w_b_idx]),
            .i_tgt   (r_st[w_tgt_idx[g]]),
            .o_tgt   (w_res[g])
        );
    end

    // Write the lane results back over their target words
    always_comb begin
        n_st = r_st;
        for (int g = 0; g < 4; g++) begin
            n_st[w_tgt_idx[g]] = w_res[g];
        end
    end

    // Sequence steps and rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_round <= '0;
            r_step  <= 2'd0;
        end else begin
            unique case (r_state)
                CS_IDLE: begin
                    if (i_start) begin
                        r_st    <= i_init;
                        r_round <= '0;
                        r_step  <= 2'd0;
                        r_state <= CS_RUN;
                    end
                end
                CS_RUN: begin
                    r_st   <= n_st;
                    r_step <= r_step + 2'd1;
                    if (r_step == STEP_A) begin
                        if (r_round == LAST_ROUND) begin
                            r_state <= CS_DONE;
                        end else begin
                            r_round <= r_round + 1'b1;
                        end
                    end
                end
                CS_DONE: begin
                    r_state <= CS_IDLE;
                end
                default: begin
                    r_state <= CS_IDLE;
                end
            endcase
        end
    end

    // Feed-forward add of the input words
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            o_block[i] = r_st[i] + i_init[i];
        end
    end

    assign o_done = (r_state == CS_DONE);

endmodule

`default_nettype wire

// File: hw/rtl/salsa20_stream_cipher.sv
// Salsa20 stream cipher top level: APB registers, chunk sequencer, keystream store.
// Depends on s20_pkg and s20_core.
//
// Usage:
//   Slave stream carries one 64-bit message chunk per word; tuser marks the start
//   of a message (reload the block counter, restart the keystream), tlast marks
//   its final chunk. The master stream returns the chunk XORed with the next eight
//   keystream bytes; bytes past the valid count read zero, the count saturates at 8.
//   Key, nonce and initial counter are 64-bit APB registers at byte address 8*i;
//   write them only while the block is idle.
// Chunk flow:
//   A chunk served from a held keystream block is accepted, then emitted.
//   A chunk that needs a fresh block first waits for the round unit, which
//   applies one quarter-round step to four lanes per cycle, plus a load step and
//   a feed-forward step. One block serves eight chunks; a new chunk is taken
//   only once the previous one has been emitted.
// Reset:
//   Synchronous active-low reset clears the APB registers and the block counter,
//   drops any held block and empties the output register.
// Stall:
//   The result waits in the output register; the next chunk is still accepted
//   and processed up to the point where its result needs that register.
`default_nettype none

module salsa20_stream_cipher import s20_pkg::*; #(
    parameter int ROUND_COUNT = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // [63:0] data_in, [67:64] bytes_valid, rest 0
    input  wire logic        i_s_tlast,   // end_of_message
    input  wire logic        i_s_tuser,   // [0] start_of_message
    // Master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [71:0] o_m_tdata,   // [63:0] data_out, [67:64] bytes_valid_out, rest 0
    output logic             o_m_tlast,   // end_of_message_out
    // APB configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [5:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    output logic      [63:0] o_prdata,
    output logic             o_pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_GEN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state          r_state;
    logic [5:0][63:0] r_cfg;
    logic [7:0][63:0] r_ks;
    logic [63:0]     r_counter;
    logic [2:0]      r_pos;
    logic            r_blk_ready;

    logic [63:0]     r_data;
    logic [3:0]      r_cnt;
    logic            r_eom;

    logic            r_out_valid;
    logic [63:0]     r_out_data;
    logic [3:0]      r_out_cnt;
    logic            r_out_eom;

    t_words          w_init;
    t_words          w_block;
    logic            w_core_done;
    logic [2:0]      w_reg_idx;
    logic            w_cfg_wr;
    logic [3:0]      w_cnt_sat;
    logic [63:0]     w_mask;
    logic            w_s_acc;

    // Build the initial state words from key, nonce and counter
    always_comb begin
        w_init[0]  = SIGMA0;
        w_init[1]  = r_cfg[REG_KEY_LOW][31:0];
        w_init[2]  = r_cfg[REG_KEY_LOW][63:32];
        w_init[3]  = r_cfg[REG_KEY_SECOND][31:0];
        w_init[4]  = r_cfg[REG_KEY_SECOND][63:32];
        w_init[5]  = SIGMA1;
        w_init[6]  = r_cfg[REG_NONCE][31:0];
        w_init[7]  = r_cfg[REG_NONCE][63:32];
        w_init[8]  = r_counter[31:0];
        w_init[9]  = r_counter[63:32];
        w_init[10] = SIGMA2;
        w_init[11] = r_cfg[REG_KEY_THIRD][31:0];
        w_init[12] = r_cfg[REG_KEY_THIRD][63:32];
        w_init[13] = r_cfg[REG_KEY_HIGH][31:0];
        w_init[14] = r_cfg[REG_KEY_HIGH][63:32];
        w_init[15] = SIGMA3;
    end

    s20_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_GEN),
        .i_init  (w_init),
        .o_done  (w_core_done),
        .o_block (w_block)
    );

    // Decode APB access
    assign w_reg_idx = i_paddr[5:3];
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite;
    assign o_pready  = 1'b1;

    always_comb begin
        o_prdata = '0;
        if (w_reg_idx <= REG_COUNTER) begin
            o_prdata = r_cfg[w_reg_idx];
        end
    end

    // Saturate the byte count and keep only valid bytes
    assign w_cnt_sat = (r_cnt > 4'd8) ? 4'd8 : r_cnt;
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[8*b +: 8] = (4'(b) < w_cnt_sat) ? 8'hFF : 8'h00;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // Sequence chunks, keystream blocks and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= '0;
            r_counter   <= '0;
            r_pos       <= 3'd0;
            r_blk_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && (w_reg_idx <= REG_COUNTER)) begin
                r_cfg[w_reg_idx] <= i_pwdata;
            end
            // Drop a taken word unless the emit step refills the register
            if (r_out_valid && i_m_tready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        r_data <= i_s_tdata[63:0];
                        r_cnt  <= i_s_tdata[67:64];
                        r_eom  <= i_s_tlast;
                        if (i_s_tuser) begin
                            r_counter   <= r_cfg[REG_COUNTER];
                            r_pos       <= 3'd0;
                            r_blk_ready <= 1'b0;
                        end
                        r_state <= (i_s_tuser || !r_blk_ready) ? ST_GEN : ST_EMIT;
                    end
                end
                ST_GEN: begin
                    if (w_core_done) begin
                        for (int i = 0; i < 8; i++) begin
                            r_ks[i] <= {w_block[2*i+1], w_block[2*i]};
                        end
                        r_counter   <= r_counter + 64'd1;
                        r_blk_ready <= 1'b1;
                        r_pos       <= 3'd0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= (r_data ^ r_ks[r_pos]) & w_mask;
                        r_out_cnt   <= w_cnt_sat;
                        r_out_eom   <= r_eom;
                        r_pos       <= r_pos + 3'd1;
                        if (r_pos == 3'd7) begin
                            r_blk_ready <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_cnt, r_out_data};
    assign o_m_tlast  = r_out_eom;

endmodule

`default_nettype wire

// File: hw/rtl/s20_checker.sv
// Port-level checks for the Salsa20 stream cipher, bound to the top level.
// Depends only on the top level's port list.
`default_nettype none

module s20_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [71:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Take one word at a time: ready drops after each accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready stayed high after accept");

    // Report a saturated byte count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[67:64] <= 4'd8) && (o_m_tdata[71:68] == 4'd0))
        else $error("byte count out of range");

endmodule

bind salsa20_stream_cipher s20_checker u_s20_checker (.*);

`default_nettype wire

// File: dv/salsa20_stream_cipher_check.sv
// Scoreboard for the Salsa20 stream cipher: mirrors the APB registers, runs its own
// Salsa20 keystream model on every accepted chunk and compares the master stream.
// Depends on s20_pkg for the register indexes and the constant words.
`default_nettype none

module salsa20_stream_cipher_check import s20_pkg::*; #(
    parameter int ROUNDS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,   // [63:0] data_in, [67:64] bytes_valid, rest 0
    input  wire logic        i_s_tlast,   // end_of_message
    input  wire logic        i_s_tuser,   // [0] start_of_message
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [71:0] i_m_tdata,   // [63:0] data_out, [67:64] bytes_valid_out, rest 0
    input  wire logic        i_m_tlast,   // end_of_message_out
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [5:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    input  wire logic [63:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        eom;
    } t_cipher_word;

    // Register mirror and keystream model state
    logic [63:0]  reg_mirror [6];
    logic [63:0]  ks_words [8];
    logic [63:0]  blk_counter;
    logic [2:0]   ks_pos;
    logic         ks_held;
    t_cipher_word ciphertext_q [$];
    int           fail_count = 0;

    logic [2:0]   apb_idx;
    t_cipher_word got_word;
    t_cipher_word want_word;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One quarter-round; returns {d, c, b, a}
    function automatic logic [127:0] quarter_round(input logic [31:0] a, input logic [31:0] b,
                                                   input logic [31:0] c, input logic [31:0] d);
        logic [31:0] nb, nc, nd, na;
        nb = b ^ rotl32(a + d, 7);
        nc = c ^ rotl32(nb + a, 9);
        nd = d ^ rotl32(nc + nb, 13);
        na = a ^ rotl32(nd + nc, 18);
        return {nd, nc, nb, na};
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Advance the keystream by one chunk and queue the expected ciphertext word
    task automatic predict_ciphertext(input logic [63:0] data, input logic [3:0] count,
                                      input logic sop, input logic eom);
        logic [31:0]  init [16];
        logic [31:0]  x [16];
        int           r;
        logic [3:0]   n;
        logic [63:0]  mask;
        logic [63:0]  ks;
        t_cipher_word w;

        if (sop) begin
            blk_counter = reg_mirror[REG_COUNTER];
            ks_held     = 1'b0;
            ks_pos      = 3'd0;
        end

        // Build a fresh block when none is held
        if (!ks_held) begin
            init[0]  = SIGMA0;
            init[1]  = reg_mirror[REG_KEY_LOW][31:0];
            init[2]  = reg_mirror[REG_KEY_LOW][63:32];
            init[3]  = reg_mirror[REG_KEY_SECOND][31:0];
            init[4]  = reg_mirror[REG_KEY_SECOND][63:32];
            init[5]  = SIGMA1;
            init[6]  = reg_mirror[REG_NONCE][31:0];
            init[7]  = reg_mirror[REG_NONCE][63:32];
            init[8]  = blk_counter[31:0];
            init[9]  = blk_counter[63:32];
            init[10] = SIGMA2;
            init[11] = reg_mirror[REG_KEY_THIRD][31:0];
            init[12] = reg_mirror[REG_KEY_THIRD][63:32];
            init[13] = reg_mirror[REG_KEY_HIGH][31:0];
            init[14] = reg_mirror[REG_KEY_HIGH][63:32];
            init[15] = SIGMA3;
            for (int i = 0; i < 16; i++)
                x[i] = init[i];

            // Column and row rounds alternate; an odd count ends on a column round
            r = 0;
            while (r < ROUNDS) begin
                {x[12], x[8], x[4], x[0]}   = quarter_round(x[0], x[4], x[8], x[12]);
                {x[1], x[13], x[9], x[5]}   = quarter_round(x[5], x[9], x[13], x[1]);
                {x[6], x[2], x[14], x[10]}  = quarter_round(x[10], x[14], x[2], x[6]);
                {x[11], x[7], x[3], x[15]}  = quarter_round(x[15], x[3], x[7], x[11]);
                r++;
                if (r < ROUNDS) begin
                    {x[3], x[2], x[1], x[0]}     = quarter_round(x[0], x[1], x[2], x[3]);
                    {x[4], x[7], x[6], x[5]}     = quarter_round(x[5], x[6], x[7], x[4]);
                    {x[9], x[8], x[11], x[10]}   = quarter_round(x[10], x[11], x[8], x[9]);
                    {x[14], x[13], x[12], x[15]} = quarter_round(x[15], x[12], x[13], x[14]);
                    r++;
                end
            end

            // Feed-forward add
            for (int i = 0; i < 8; i++)
                ks_words[i] = {x[2*i+1] + init[2*i+1], x[2*i] + init[2*i]};
            blk_counter = blk_counter + 64'd1;
            ks_held     = 1'b1;
            ks_pos      = 3'd0;
        end

        ks     = ks_words[ks_pos];
        ks_pos = ks_pos + 3'd1;
        if (ks_pos == 3'd0)
            ks_held = 1'b0;

        // Saturate the count and clear bytes past it
        n    = (count > 4'd8) ? 4'd8 : count;
        mask = (n == 4'd8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);

        w.data  = (data ^ ks) & mask;
        w.count = n;
        w.eom   = eom;
        ciphertext_q.push_back(w);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++)
                reg_mirror[i] = 64'd0;
            for (int i = 0; i < 8; i++)
                ks_words[i] = 64'd0;
            blk_counter = 64'd0;
            ks_pos      = 3'd0;
            ks_held     = 1'b0;
            ciphertext_q.delete();
        end else begin
            // Track register writes, check reads
            apb_idx = i_paddr[5:3];
            if (i_psel && i_penable && i_pready && apb_idx <= REG_COUNTER) begin
                if (i_pwrite)
                    reg_mirror[apb_idx] = i_pwdata;
                else if (i_prdata !== reg_mirror[apb_idx])
                    note_mismatch("register read", reg_mirror[apb_idx], i_prdata);
            end

            // Compare the output word against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got_word.data  = i_m_tdata[63:0];
                got_word.count = i_m_tdata[67:64];
                got_word.eom   = i_m_tlast;
                if (ciphertext_q.size() == 0) begin
                    note_mismatch("unexpected output word", 64'd0, got_word.data);
                end else begin
                    want_word = ciphertext_q.pop_front();
                    if (got_word.data !== want_word.data)
                        note_mismatch("data_out", want_word.data, got_word.data);
                    if (got_word.count !== want_word.count)
                        note_mismatch("bytes_valid_out", 64'(want_word.count),
                                      64'(got_word.count));
                    if (got_word.eom !== want_word.eom)
                        note_mismatch("end_of_message_out", 64'(want_word.eom),
                                      64'(got_word.eom));
                end
            end

            // Predict the input word accepted at this edge
            if (i_s_tvalid && i_s_tready)
                predict_ciphertext(i_s_tdata[63:0], i_s_tdata[67:64], i_s_tuser, i_s_tlast);
        end
        o_pending    <= ciphertext_q.size();
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

// File: dv/salsa20_stream_cipher_test.sv
// Testbench top for the Salsa20 stream cipher: clock, reset, APB programming and
// chunk stimulus with random gaps. Depends on s20_pkg, salsa20_stream_cipher and
// salsa20_stream_cipher_check, which does all prediction and comparison.
`default_nettype none

module salsa20_stream_cipher_test import s20_pkg::*;;

    localparam int         ROUNDS         = 20;
    localparam int         WATCHDOG_LIMIT = 3000;
    // Addresses past the register file; writes there must be ignored
    localparam logic [2:0] REG_SPARE_A    = 3'd6;
    localparam logic [2:0] REG_SPARE_B    = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [71:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [5:0]  paddr     = '0;
    logic [63:0] pwdata    = '0;

    wire logic        o_s_tready;
    wire logic        o_m_tvalid;
    wire logic [71:0] o_m_tdata;
    wire logic        o_m_tlast;
    wire logic [63:0] o_prdata;
    wire logic        o_pready;

    int fail_count;
    int pending;
    bit quiet       = 1'b0;
    int stall_left  = 0;
    int ready_gap   = 0;
    int idle_cycles = 0;

    salsa20_stream_cipher #(
        .ROUND_COUNT(ROUNDS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    salsa20_stream_cipher_check #(
        .ROUNDS(ROUNDS)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (o_prdata),
        .i_pready     (o_pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random 64-bit word with the extremes mixed in
    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 64'd0;
        if (r == 1)
            return {64{1'b1}};
        return {$urandom, $urandom};
    endfunction

    // Counter start values near the 32-bit carry and the 64-bit wrap
    function automatic logic [63:0] pick_counter();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return {64{1'b1}} - 64'($urandom_range(0, 2));
        if (r == 1)
            return {32'd0, 32'hffff_ffff} - 64'($urandom_range(0, 2));
        return pick_word();
    endfunction

    // Output side: random stalls on tready
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else begin
            ready_gap = pick_gap();
            if (ready_gap > 0) begin
                m_tready   = 1'b0;
                stall_left = ready_gap - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || (psel && penable) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Send one chunk after a random gap; returns at the falling edge after acceptance
    task automatic send_chunk(input logic [63:0] data, input logic [3:0] count,
                              input logic sop, input logic eom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {4'd0, count, data};
        s_tuser  = sop;
        s_tlast  = eom;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!o_s_tready);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] idx,
                              input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!o_pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Wait for the block to drain, then load key, nonce and counter and read them back
    task automatic program_keys(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] nonce, input logic [63:0] ctr);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        apb_access(1'b1, REG_KEY_LOW, k0);
        apb_access(1'b1, REG_KEY_SECOND, k1);
        apb_access(1'b1, REG_KEY_THIRD, k2);
        apb_access(1'b1, REG_KEY_HIGH, k3);
        apb_access(1'b1, REG_NONCE, nonce);
        apb_access(1'b1, REG_COUNTER, ctr);
        apb_access(1'b1, REG_SPARE_A, pick_word());
        apb_access(1'b1, REG_SPARE_B, pick_word());
        apb_access(1'b0, REG_KEY_LOW, 64'd0);
        apb_access(1'b0, REG_KEY_SECOND, 64'd0);
        apb_access(1'b0, REG_KEY_THIRD, 64'd0);
        apb_access(1'b0, REG_KEY_HIGH, 64'd0);
        apb_access(1'b0, REG_NONCE, 64'd0);
        apb_access(1'b0, REG_COUNTER, 64'd0);
    endtask

    initial begin
        int          sent;
        int          len;
        logic [3:0]  last_count;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset key: data extremes, zero count, saturated counts, short chunks,
        // end marks without a start, a block boundary and a restart mid-block
        send_chunk(64'd0, 4'd8, 1'b1, 1'b0);
        send_chunk({64{1'b1}}, 4'd8, 1'b0, 1'b0);
        send_chunk(pick_word(), 4'd0, 1'b0, 1'b0);
        send_chunk(pick_word(), 4'd1, 1'b0, 1'b0);
        send_chunk(pick_word(), 4'd7, 1'b0, 1'b1);
        send_chunk(pick_word(), 4'd9, 1'b0, 1'b0);
        send_chunk(pick_word(), 4'd15, 1'b0, 1'b0);
        send_chunk(pick_word(), 4'd8, 1'b0, 1'b0);
        send_chunk(pick_word(), 4'd8, 1'b0, 1'b1);
        send_chunk(pick_word(), 4'd3, 1'b1, 1'b1);

        // All-ones key and nonce; counter wraps after the first block
        program_keys({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                     {64{1'b1}});
        for (int i = 0; i < 10; i++)
            send_chunk(pick_word(), 4'd8, i == 0, i == 9);

        // Random phases: mostly well-formed messages, some stray chunks
        for (int phase = 0; phase < 8; phase++) begin
            program_keys(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_counter());
            quiet = (phase % 3 == 2);
            sent  = 0;
            while (sent < 122) begin
                if ($urandom_range(0, 99) < 85) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 20);
                    last_count = 4'($urandom_range(1, 8));
                    for (int i = 0; i < len; i++)
                        send_chunk(pick_word(), (i == len - 1) ? last_count : 4'd8,
                                   i == 0, i == len - 1);
                    sent += len;
                end else begin
                    send_chunk(pick_word(), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
        quiet    = 1'b0;
        s_tvalid = 1'b0;

        // Drain and let the pipeline settle
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/s20_pkg.sv
hw/rtl/s20_arx.sv
hw/rtl/s20_core.sv
hw/rtl/salsa20_stream_cipher.sv
hw/rtl/s20_checker.sv
dv/salsa20_stream_cipher_check.sv
dv/salsa20_stream_cipher_test.sv
